// ----- rtl/smt_pkg.sv -----
// shared constants, types and exp tables for the softmax with temperature block
package smt_pkg;

	// row geometry
	localparam int ROW_MAX = 64;
	localparam int ADDR_W = $clog2(ROW_MAX);
	localparam int CNT_W = $clog2(ROW_MAX + 1);

	// exp in Q0.16 spans 0..65536, sum of a full row
	localparam int E16_W = 17;
	localparam int SUM_W = $clog2(ROW_MAX * 65536 + 1);

	// shared divider widths: probability dividend is e16 * 2^16 + sum / 2
	localparam int DIV_N_W = E16_W + 16;
	localparam int DIV_D_W = SUM_W;
	localparam int DIV_C_W = $clog2(DIV_N_W);

	// fixed-point constants
	localparam logic [15:0] UNITY_TEMP = 16'd256;
	localparam logic [15:0] EXP_CUTOFF = 16'd4096;
	localparam logic signed [15:0] MOST_NEG = 16'sh8000;
	localparam int TAYLOR_TERMS = 12;
	localparam int Q30_W = 31;

	typedef logic [Q30_W-1:0] exp_tab_t [256];

	// exp(-y) for y in Q0.30, 0 <= y <= 1.0, Horner form of the Taylor series
	function automatic logic [63:0] exp_neg_series(input logic [63:0] y);
		logic [63:0] r;
		logic [63:0] t;
		r = 64'd1 << 30;
		for (int k = TAYLOR_TERMS; k >= 1; k--) begin
			t = (y * r) >> 30;
			r = (64'd1 << 30) - t / 64'(k);
		end
		return r;
	endfunction

	// exp of minus the fractional part b/256 for every b
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		for (int b = 0; b < 256; b++) begin
			tab[b] = Q30_W'(exp_neg_series(64'(b) << 22));
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_FRAC_TAB = build_exp_tab();
	localparam logic [Q30_W-1:0] EXP_ONE_STEP = Q30_W'(exp_neg_series(64'd1 << 30));

	// one entry of the queue between front and back
	typedef struct packed {
		logic signed [15:0] value;
		logic last;
	} smt_entry_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [0:0] {
		X_IDLE,
		X_MUL
	} exp_state_t;

	typedef enum logic [3:0] {
		B_LOAD,
		B_SUM_RD,
		B_SUM_EXP,
		B_SUM_WAIT,
		B_OUT_RD,
		B_OUT_EXP,
		B_OUT_WAIT,
		B_OUT_DIV,
		B_OUT_PUT
	} back_state_t;

endpackage

// ----- rtl/smt_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module smt_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [smt_pkg::DIV_N_W-1:0]  dividend,
	input  logic [smt_pkg::DIV_D_W-1:0]  divisor,
	output logic                         done,
	output logic [smt_pkg::DIV_N_W-1:0]  quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [smt_pkg::DIV_C_W-1:0]   cnt_q;
	logic [smt_pkg::DIV_D_W-1:0]   rem_q;
	logic [smt_pkg::DIV_D_W-1:0]   den_q;
	logic [smt_pkg::DIV_N_W-1:0]   quo_q;
	logic [smt_pkg::DIV_D_W:0]     shifted;
	logic [smt_pkg::DIV_D_W:0]     diff;
	logic                          fits;

	// trial subtract of the next partial remainder
	always_comb begin
		shifted = {rem_q, quo_q[smt_pkg::DIV_N_W-1]};
		diff = shifted - {1'b0, den_q};
		fits = (shifted >= {1'b0, den_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= smt_pkg::DIV_C_W'(smt_pkg::DIV_N_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[smt_pkg::DIV_D_W-1:0] : shifted[smt_pkg::DIV_D_W-1:0];
			quo_q <= {quo_q[smt_pkg::DIV_N_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/smt_exp.sv -----
// exp(-d/256) in Q0.16: zero above the cutoff, table for the fraction, repeated multiply for the integer part
module smt_exp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [15:0]                 d,
	output logic                        done,
	output logic [smt_pkg::E16_W-1:0]   e16
);

	smt_pkg::exp_state_t state_q, state_d;
	logic [smt_pkg::Q30_W-1:0]    v_q;
	logic [4:0]                   a_q;
	logic [smt_pkg::E16_W-1:0]    e16_q;
	logic                         done_q;
	logic [2*smt_pkg::Q30_W-1:0]  prod;
	logic [smt_pkg::Q30_W:0]      rounded;
	logic                         cut;

	assign cut = (d > smt_pkg::EXP_CUTOFF);
	assign prod = v_q * smt_pkg::EXP_ONE_STEP;
	assign rounded = {1'b0, v_q} + (smt_pkg::Q30_W + 1)'(8192);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			smt_pkg::X_IDLE: begin
				if (start && !cut) state_d = smt_pkg::X_MUL;
			end
			smt_pkg::X_MUL: begin
				if (a_q == '0) state_d = smt_pkg::X_IDLE;
			end
			default: state_d = smt_pkg::X_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smt_pkg::X_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == smt_pkg::X_IDLE && start && cut)
				|| (state_q == smt_pkg::X_MUL && a_q == '0);
		end
	end

	// one truncated Q0.30 product per cycle
	always_ff @(posedge clk) begin
		if (state_q == smt_pkg::X_IDLE && start) begin
			v_q <= smt_pkg::EXP_FRAC_TAB[d[7:0]];
			a_q <= d[12:8];
			if (cut) e16_q <= '0;
		end else if (state_q == smt_pkg::X_MUL) begin
			if (a_q == '0) begin
				e16_q <= rounded[smt_pkg::Q30_W-1:14];
			end else begin
				v_q <= prod[60:30];
				a_q <= a_q - 1'b1;
			end
		end
	end

	assign done = done_q;
	assign e16 = e16_q;

endmodule

// ----- rtl/smt_front.sv -----
// front part: accepts logits, scales by 1/temperature unless it is zero or unity, hands entries to the queue
module smt_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic signed [15:0]    logit,
	input  logic                  last_in_row,
	input  logic                  temperature_we,
	input  logic [15:0]           temperature,
	input  logic                  q_full,
	output logic                  q_push,
	output smt_pkg::smt_entry_t   q_entry
);

	smt_pkg::front_state_t state_q, state_d;
	logic [15:0]                  temp_q;
	logic signed [15:0]           val_q;
	logic                         last_q;
	logic                         neg_q;
	logic                         accept;
	logic                         bypass;
	logic [15:0]                  mag;
	logic                         div_done;
	logic [smt_pkg::DIV_N_W-1:0]  quo;
	logic [16:0]                  sat;
	logic [16:0]                  neg_sat;

	assign accept = push && (state_q == smt_pkg::F_IDLE);
	assign bypass = (temp_q == '0) || (temp_q == smt_pkg::UNITY_TEMP);
	assign mag = logit[15] ? 16'(-logit) : logit;
	assign full = (state_q != smt_pkg::F_IDLE);
	assign q_push = (state_q == smt_pkg::F_PUSH) && !q_full;
	assign q_entry = '{value: val_q, last: last_q};

	// magnitude * 256 + temperature / 2, divided by temperature
	smt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && !bypass),
		.dividend (smt_pkg::DIV_N_W'({mag, 8'h00}) + smt_pkg::DIV_N_W'(temp_q[15:1])),
		.divisor  (smt_pkg::DIV_D_W'(temp_q)),
		.done     (div_done),
		.quotient (quo)
	);

	// saturate to 32767 or -32768 and apply the sign
	always_comb begin
		if (neg_q) begin
			sat = (quo > smt_pkg::DIV_N_W'(32768)) ? 17'd32768 : quo[16:0];
		end else begin
			sat = (quo > smt_pkg::DIV_N_W'(32767)) ? 17'd32767 : quo[16:0];
		end
		neg_sat = ~sat + 17'd1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			smt_pkg::F_IDLE: if (accept) state_d = bypass ? smt_pkg::F_PUSH : smt_pkg::F_DIV;
			smt_pkg::F_DIV:  if (div_done) state_d = smt_pkg::F_PUSH;
			smt_pkg::F_PUSH: if (!q_full) state_d = smt_pkg::F_IDLE;
			default:         state_d = smt_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smt_pkg::F_IDLE;
			temp_q <= smt_pkg::UNITY_TEMP;
		end else begin
			state_q <= state_d;
			if (temperature_we) temp_q <= temperature;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= logit;
			last_q <= last_in_row;
			neg_q <= logit[15];
		end else if (state_q == smt_pkg::F_DIV && div_done) begin
			val_q <= neg_q ? neg_sat[15:0] : sat[15:0];
		end
	end

endmodule

// ----- rtl/smt_back.sv -----
// back part: row store, running max, exp sum pass and probability pass
module smt_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  smt_pkg::smt_entry_t   q_entry,
	output logic                  q_pop,
	output logic                  empty,
	input  logic                  pop,
	output logic [15:0]           probability,
	output logic                  last_out,
	output logic                  row_overflow
);

	smt_pkg::back_state_t state_q, state_d;
	logic signed [15:0]           row_mem [smt_pkg::ROW_MAX];
	logic signed [15:0]           rd_data_q;
	logic [smt_pkg::CNT_W-1:0]    count_q;
	logic [smt_pkg::CNT_W-1:0]    idx_q;
	logic signed [15:0]           max_q;
	logic                         ovf_q;
	logic [smt_pkg::SUM_W-1:0]    sum_q;
	logic [15:0]                  p_q;
	logic                         out_valid_q;
	logic [15:0]                  prob_q;
	logic                         last_out_q;
	logic                         ovf_out_q;
	logic                         room;
	logic                         mem_we;
	logic                         last_elem;
	logic                         load_out;
	logic [16:0]                  diff;
	logic                         exp_start;
	logic                         exp_done;
	logic [smt_pkg::E16_W-1:0]    e16;
	logic                         div_start;
	logic                         div_done;
	logic [smt_pkg::DIV_N_W-1:0]  quo;

	assign room = (count_q < smt_pkg::CNT_W'(smt_pkg::ROW_MAX));
	assign q_pop = (state_q == smt_pkg::B_LOAD) && !q_empty;
	assign mem_we = q_pop && room;
	assign last_elem = ((idx_q + 1'b1) == count_q);
	assign load_out = (state_q == smt_pkg::B_OUT_PUT) && (!out_valid_q || pop);
	assign diff = {max_q[15], max_q} - {rd_data_q[15], rd_data_q};
	assign exp_start = (state_q == smt_pkg::B_SUM_EXP) || (state_q == smt_pkg::B_OUT_EXP);
	assign div_start = (state_q == smt_pkg::B_OUT_WAIT) && exp_done;

	smt_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.d      (diff[15:0]),
		.done   (exp_done),
		.e16    (e16)
	);

	// e16 * 2^16 + sum / 2, divided by sum
	smt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({e16, 16'h0000} + smt_pkg::DIV_N_W'(sum_q[smt_pkg::SUM_W-1:1])),
		.divisor  (smt_pkg::DIV_D_W'(sum_q)),
		.done     (div_done),
		.quotient (quo)
	);

	// row store
	always_ff @(posedge clk) begin
		if (mem_we) row_mem[count_q[smt_pkg::ADDR_W-1:0]] <= q_entry.value;
	end

	always_ff @(posedge clk) begin
		rd_data_q <= row_mem[idx_q[smt_pkg::ADDR_W-1:0]];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			smt_pkg::B_LOAD:     if (q_pop && q_entry.last) state_d = smt_pkg::B_SUM_RD;
			smt_pkg::B_SUM_RD:   state_d = smt_pkg::B_SUM_EXP;
			smt_pkg::B_SUM_EXP:  state_d = smt_pkg::B_SUM_WAIT;
			smt_pkg::B_SUM_WAIT: begin
				if (exp_done) state_d = last_elem ? smt_pkg::B_OUT_RD : smt_pkg::B_SUM_RD;
			end
			smt_pkg::B_OUT_RD:   state_d = smt_pkg::B_OUT_EXP;
			smt_pkg::B_OUT_EXP:  state_d = smt_pkg::B_OUT_WAIT;
			smt_pkg::B_OUT_WAIT: if (exp_done) state_d = smt_pkg::B_OUT_DIV;
			smt_pkg::B_OUT_DIV:  if (div_done) state_d = smt_pkg::B_OUT_PUT;
			smt_pkg::B_OUT_PUT: begin
				if (load_out) state_d = last_elem ? smt_pkg::B_LOAD : smt_pkg::B_OUT_RD;
			end
			default:             state_d = smt_pkg::B_LOAD;
		endcase
	end

	// row control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smt_pkg::B_LOAD;
			count_q <= '0;
			max_q <= smt_pkg::MOST_NEG;
			ovf_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				if (room) begin
					count_q <= count_q + 1'b1;
					if (q_entry.value > max_q) max_q <= q_entry.value;
				end else begin
					ovf_q <= 1'b1;
				end
				if (q_entry.last) idx_q <= '0;
			end
			if (state_q == smt_pkg::B_SUM_WAIT && exp_done) begin
				idx_q <= last_elem ? '0 : idx_q + 1'b1;
			end
			if (load_out) begin
				idx_q <= last_elem ? '0 : idx_q + 1'b1;
				if (last_elem) begin
					count_q <= '0;
					max_q <= smt_pkg::MOST_NEG;
					ovf_q <= 1'b0;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sum, probability and output register
	always_ff @(posedge clk) begin
		if (q_pop && q_entry.last) sum_q <= '0;
		if (state_q == smt_pkg::B_SUM_WAIT && exp_done) begin
			sum_q <= sum_q + smt_pkg::SUM_W'(e16);
		end
		if (state_q == smt_pkg::B_OUT_DIV && div_done) begin
			p_q <= (quo > smt_pkg::DIV_N_W'(65535)) ? 16'hFFFF : quo[15:0];
		end
		if (load_out) begin
			prob_q <= p_q;
			last_out_q <= last_elem;
			ovf_out_q <= ovf_q;
		end
	end

	assign empty = !out_valid_q;
	assign probability = prob_q;
	assign last_out = last_out_q;
	assign row_overflow = ovf_out_q;

endmodule

// ----- rtl/softmax_with_temperature.sv -----
// top level of the softmax with temperature block: front, entry queue and back
//
// channel      | ports                                   | transfer when
// logits in    | push, full, logit, last_in_row          | push && !full
// results out  | pop, empty, probability, last_out,      | pop && !empty
//              | row_overflow                            |
// temperature  | temperature_we, temperature             | temperature_we
//
// An item goes straight to the queue at unity or zero temperature and
// through the divider otherwise. At row end the back walks the row store
// twice: a sum pass of exp per element, and an output pass of exp, divide
// and any wait on pop per element, each exp doing a multiplies, a being
// the integer part of max - x (up to 16 exp multiplies).
// Reset is asynchronous and needs no clearing pass. The 4-entry queue lets the
// front keep taking logits while the back emits or waits on pop, till full.
module softmax_with_temperature (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic signed [15:0]  logit,
	input  logic                last_in_row,
	input  logic                temperature_we,
	input  logic [15:0]         temperature,
	output logic                empty,
	input  logic                pop,
	output logic [15:0]         probability,
	output logic                last_out,
	output logic                row_overflow
);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	smt_pkg::smt_entry_t  q_mem [QDEPTH];
	smt_pkg::smt_entry_t  q_in;
	smt_pkg::smt_entry_t  q_out;
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QPTR_W:0]      fill_q;
	logic                 q_push;
	logic                 q_pop;
	logic                 q_full;
	logic                 q_empty;

	smt_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.logit          (logit),
		.last_in_row    (last_in_row),
		.temperature_we (temperature_we),
		.temperature    (temperature),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_entry        (q_in)
	);

	// entry queue between front and back
	assign q_full = (fill_q == (QPTR_W + 1)'(QDEPTH));
	assign q_empty = (fill_q == '0);
	assign q_out = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_push) q_mem[wr_ptr_q] <= q_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (q_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (q_push && !q_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (q_pop && !q_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	smt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_entry      (q_out),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.probability  (probability),
		.last_out     (last_out),
		.row_overflow (row_overflow)
	);

endmodule
